// ===== rtl/tptm_pkg.sv =====
// Shared constants, command codes and entry-bit helpers for the page table manager.
package tptm_pkg;

    localparam int DIR_INDEX_BITS_DEF   = 10;
    localparam int TABLE_INDEX_BITS_DEF = 10;

    localparam int PAGE_SHIFT  = 12;
    localparam int FRAME_WIDTH = 20;
    localparam int ENTRY_WIDTH = 32;

    typedef logic [2:0]             command_t;
    typedef logic [PAGE_SHIFT-1:0]  low_bits_t;
    typedef logic [FRAME_WIDTH-1:0] frame_t;
    typedef logic [ENTRY_WIDTH-1:0] entry_t;

    localparam command_t CMD_MAP   = 3'd0;
    localparam command_t CMD_UNMAP = 3'd1;
    localparam command_t CMD_QUERY = 3'd2;
    localparam command_t CMD_GET   = 3'd3;
    localparam command_t CMD_SET   = 3'd4;

    // Entry bit positions
    localparam int B_PRESENT = 0;
    localparam int B_WRITE   = 1;
    localparam int B_USER    = 2;
    localparam int B_WTHRU   = 3;
    localparam int B_NOCACHE = 4;
    localparam int B_LARGE   = 7;
    localparam int B_GLOBAL  = 8;
    localparam int B_SWAPPED = 9;
    localparam int B_COW     = 10;

    localparam low_bits_t E_PRESENT = 12'h001;
    localparam low_bits_t E_WRITE   = 12'h002;
    localparam low_bits_t E_USER    = 12'h004;
    localparam low_bits_t E_WTHRU   = 12'h008;
    localparam low_bits_t E_NOCACHE = 12'h010;
    localparam low_bits_t E_GLOBAL  = 12'h100;
    localparam low_bits_t E_SWAPPED = 12'h200;
    localparam low_bits_t E_COW     = 12'h400;

    // Build the low twelve bits of a page entry from the request flags
    function automatic low_bits_t page_bits(
        input logic kernel,
        input logic wr,
        input logic wt,
        input logic cd,
        input logic sw,
        input logic cow
    );
        low_bits_t b;
        b = '0;
        b = b | (kernel ? E_GLOBAL : E_USER);
        if (wr)  b = b | E_WRITE;
        if (wt)  b = b | E_WTHRU;
        if (cd)  b = b | E_NOCACHE;
        b = b | (sw ? E_SWAPPED : E_PRESENT);
        if (cow) b = b | E_COW;
        return b;
    endfunction

    // Directory entry for a freshly created table: always present, writable, user
    function automatic entry_t new_dir_entry(input frame_t tframe, input low_bits_t bits);
        low_bits_t b;
        b = (bits & ~(E_GLOBAL | E_SWAPPED | E_COW)) | E_USER | E_WRITE | E_PRESENT;
        return {tframe, b};
    endfunction

endpackage

// ===== rtl/two_level_page_table_manager.sv =====
// Two-level page table manager: directory and table memories with a command sequencer.
//
// Commands are taken with start while busy is low; each gives exactly one result,
// shown for one cycle with done high. Most commands read the directory and table at
// the accepting edge and do one read-modify-write in the execute state, from which
// done is registered; busy is low again while done is high, so a new command can be
// accepted in that cycle. A map to a directory slot that is not yet present also
// clears that slot's table through the single table write port, one entry a cycle,
// with busy high, and done rises as the clear ends. After reset the directory memory
// is swept to zero, one entry a cycle, with busy high. Results cannot be held off and
// must be taken in the cycle done is high.
module two_level_page_table_manager
    import tptm_pkg::*;
#(
    parameter int DIR_INDEX_BITS   = DIR_INDEX_BITS_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] virtual_address,
    input  logic [19:0] physical_frame,
    input  logic [19:0] table_frame,
    input  logic        kernel_mode,
    input  logic        writable,
    input  logic        write_through,
    input  logic        cache_disable,
    input  logic        swapped_out,
    input  logic        copy_on_write,
    output logic        done,
    output logic        success,
    output logic        misuse,
    output logic [19:0] out_frame,
    output logic        out_kernel_mode,
    output logic        out_writable,
    output logic        out_write_through,
    output logic        out_cache_disable,
    output logic        out_swapped,
    output logic        out_copy_on_write
);

    localparam int SLOT_BITS  = DIR_INDEX_BITS + TABLE_INDEX_BITS;
    localparam int DIR_DEPTH  = 1 << DIR_INDEX_BITS;
    localparam int TBL_DEPTH  = 1 << SLOT_BITS;
    localparam int CNT_BITS   = (DIR_INDEX_BITS > TABLE_INDEX_BITS) ?
                                DIR_INDEX_BITS : TABLE_INDEX_BITS;

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_CLR  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        done_reg, done_next;

    // Latched command
    command_t                    cmd_reg;
    logic [DIR_INDEX_BITS-1:0]   di_reg;
    logic [TABLE_INDEX_BITS-1:0] ti_reg;
    frame_t                      pframe_reg;
    frame_t                      tframe_reg;
    low_bits_t                   bits_reg;

    // Result register
    logic                        success_reg, success_next;
    logic                        misuse_reg, misuse_next;
    entry_t                      ent_out_reg, ent_out_next;

    // Memories
    entry_t                      dir_mem [DIR_DEPTH];
    entry_t                      tbl_mem [TBL_DEPTH];
    entry_t                      dir_rd_reg;
    entry_t                      tbl_rd_reg;
    logic                        dir_we;
    logic [DIR_INDEX_BITS-1:0]   dir_waddr;
    entry_t                      dir_wdata;
    logic                        tbl_we;
    logic [SLOT_BITS-1:0]        tbl_waddr;
    entry_t                      tbl_wdata;

    logic [DIR_INDEX_BITS-1:0]   in_di;
    logic [TABLE_INDEX_BITS-1:0] in_ti;
    logic                        accept;
    logic                        dir_ok;
    logic                        dir_large;
    logic                        entry_found;
    logic                        clr_last;

    assign in_di  = virtual_address[PAGE_SHIFT + TABLE_INDEX_BITS +: DIR_INDEX_BITS];
    assign in_ti  = virtual_address[PAGE_SHIFT +: TABLE_INDEX_BITS];
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign dir_ok      = dir_rd_reg[B_PRESENT];
    assign dir_large   = dir_rd_reg[B_LARGE];
    assign entry_found = tbl_rd_reg[B_PRESENT] | tbl_rd_reg[B_SWAPPED];
    assign clr_last    = &cnt_reg[TABLE_INDEX_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rd_reg <= dir_mem[in_di];
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[{in_di, in_ti}];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= command;
            di_reg     <= in_di;
            ti_reg     <= in_ti;
            pframe_reg <= physical_frame;
            tframe_reg <= table_frame;
            bits_reg   <= page_bits(kernel_mode, writable, write_through,
                                    cache_disable, swapped_out, copy_on_write);
        end
        success_reg <= success_next;
        misuse_reg  <= misuse_next;
        ent_out_reg <= ent_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        success_next = 1'b0;
        misuse_next  = 1'b0;
        ent_out_next = '0;
        dir_we       = 1'b0;
        dir_waddr    = di_reg;
        dir_wdata    = dir_rd_reg;
        tbl_we       = 1'b0;
        tbl_waddr    = {di_reg, ti_reg};
        tbl_wdata    = '0;

        unique case (state_reg)
            S_INIT:
            begin
                // Sweep the directory to zero after reset
                dir_we    = 1'b1;
                dir_waddr = cnt_reg[DIR_INDEX_BITS-1:0];
                dir_wdata = '0;
                if (&cnt_reg[DIR_INDEX_BITS-1:0])
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                unique case (cmd_reg) inside
                    CMD_MAP:
                    begin
                        if (!dir_ok)
                        begin
                            dir_we     = 1'b1;
                            dir_wdata  = new_dir_entry(tframe_reg, bits_reg);
                            done_next  = 1'b0;
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        else
                        begin
                            if (bits_reg[B_USER] && !dir_rd_reg[B_USER])
                            begin
                                dir_we    = 1'b1;
                                dir_wdata = dir_rd_reg | {{(ENTRY_WIDTH-PAGE_SHIFT){1'b0}},
                                                          E_USER};
                            end
                            if (!tbl_rd_reg[B_PRESENT])
                            begin
                                tbl_we       = 1'b1;
                                tbl_wdata    = {pframe_reg, bits_reg};
                                success_next = 1'b1;
                            end
                        end
                    end

                    CMD_QUERY:
                    begin
                        success_next = dir_ok && (dir_large || tbl_rd_reg[B_PRESENT]);
                    end

                    CMD_UNMAP, CMD_GET, CMD_SET:
                    begin
                        if (!dir_ok || dir_large || !entry_found)
                        begin
                            misuse_next = 1'b1;
                        end
                        else
                        begin
                            success_next = 1'b1;
                            if (cmd_reg == CMD_UNMAP)
                            begin
                                tbl_we    = 1'b1;
                                tbl_wdata = '0;
                            end
                            else if (cmd_reg == CMD_SET)
                            begin
                                tbl_we    = 1'b1;
                                tbl_wdata = {tbl_rd_reg[ENTRY_WIDTH-1:PAGE_SHIFT], bits_reg};
                            end
                            else
                            begin
                                ent_out_next = tbl_rd_reg;
                            end
                        end
                    end

                    default:
                    begin
                        // Unused codes: no change, all-zero result
                    end
                endcase
            end

            S_CLR:
            begin
                // Clear the new table; drop the mapped entry in on the way past
                tbl_we    = 1'b1;
                tbl_waddr = {di_reg, cnt_reg[TABLE_INDEX_BITS-1:0]};
                tbl_wdata = (cnt_reg[TABLE_INDEX_BITS-1:0] == ti_reg) ?
                            {pframe_reg, bits_reg} : '0;
                if (clr_last)
                begin
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    success_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done              = done_reg;
    assign success           = success_reg;
    assign misuse            = misuse_reg;
    assign out_frame         = ent_out_reg[ENTRY_WIDTH-1:PAGE_SHIFT];
    assign out_kernel_mode   = (ent_out_reg != '0) && !ent_out_reg[B_USER];
    assign out_writable      = ent_out_reg[B_WRITE];
    assign out_write_through = ent_out_reg[B_WTHRU];
    assign out_cache_disable = ent_out_reg[B_NOCACHE];
    assign out_swapped       = ent_out_reg[B_SWAPPED];
    assign out_copy_on_write = ent_out_reg[B_COW];

`ifndef ASSERT_OFF
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC || state_reg == S_CLR))
        else $error("result strobe without a finished command");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(success && misuse))
        else $error("success and misuse both set");

    a_misuse_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && misuse) |-> (cmd_reg == CMD_UNMAP || cmd_reg == CMD_GET ||
                              cmd_reg == CMD_SET))
        else $error("misuse reported for a command that cannot misuse");

    a_frame_get: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_frame != '0) |-> (cmd_reg == CMD_GET))
        else $error("frame returned for a command other than get");

    a_clr_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> (cmd_reg == CMD_MAP))
        else $error("table clear outside a map");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the two-level page table manager: directed and random commands.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tptm_pkg::*;

    localparam int DIR_SLOTS      = 1 << DIR_INDEX_BITS_DEF;
    localparam int TABLE_SLOTS    = 1 << TABLE_INDEX_BITS_DEF;
    localparam int DIR_SHIFT      = PAGE_SHIFT + TABLE_INDEX_BITS_DEF;
    localparam int RANDOM_ITEMS   = 580;
    localparam int TAIL_ITEMS     = 80;
    localparam int DRAIN_CYCLES   = 3000;
    localparam int CYCLE_LIMIT    = 3_000_000;

    localparam command_t CMD_SPARE5 = 3'd5;
    localparam command_t CMD_SPARE6 = 3'd6;
    localparam command_t CMD_SPARE7 = 3'd7;

    typedef struct {
        command_t    cmd;
        logic [31:0] va;
        frame_t      pframe;
        frame_t      tframe;
        logic        kern;
        logic        wr;
        logic        wt;
        logic        cd;
        logic        sw;
        logic        cow;
    } request_t;

    typedef struct {
        logic   hit;
        logic   misuse;
        frame_t frame;
        logic   kern;
        logic   wr;
        logic   wt;
        logic   cd;
        logic   sw;
        logic   cow;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  command = '0;
    logic [31:0] virtual_address = '0;
    logic [19:0] physical_frame = '0;
    logic [19:0] table_frame = '0;
    logic        kernel_mode = 1'b0;
    logic        writable = 1'b0;
    logic        write_through = 1'b0;
    logic        cache_disable = 1'b0;
    logic        swapped_out = 1'b0;
    logic        copy_on_write = 1'b0;
    logic        done;
    logic        success;
    logic        misuse;
    logic [19:0] out_frame;
    logic        out_kernel_mode;
    logic        out_writable;
    logic        out_write_through;
    logic        out_cache_disable;
    logic        out_swapped;
    logic        out_copy_on_write;

    request_t request_queue[$];
    outcome_t pending_outcomes[$];

    entry_t dir_model [DIR_SLOTS];
    entry_t table_model [int unsigned];

    int errors;
    int cycles;
    int tables_created;
    int pages_installed;
    int misuse_seen;
    int cmd_count [8];
    int gap_left;
    int quiet_left;
    int unsigned dir_pick [6];
    int unsigned slot_pick [12];

    two_level_page_table_manager DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .command           (command),
        .virtual_address   (virtual_address),
        .physical_frame    (physical_frame),
        .table_frame       (table_frame),
        .kernel_mode       (kernel_mode),
        .writable          (writable),
        .write_through     (write_through),
        .cache_disable     (cache_disable),
        .swapped_out       (swapped_out),
        .copy_on_write     (copy_on_write),
        .done              (done),
        .success           (success),
        .misuse            (misuse),
        .out_frame         (out_frame),
        .out_kernel_mode   (out_kernel_mode),
        .out_writable      (out_writable),
        .out_write_through (out_write_through),
        .out_cache_disable (out_cache_disable),
        .out_swapped       (out_swapped),
        .out_copy_on_write (out_copy_on_write)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_request(command_t cmd, logic [31:0] va, frame_t pf, frame_t tf,
                                logic kern, logic wr, logic wt, logic cd, logic sw, logic cow);
        request_t r;
        r.cmd    = cmd;
        r.va     = va;
        r.pframe = pf;
        r.tframe = tf;
        r.kern   = kern;
        r.wr     = wr;
        r.wt     = wt;
        r.cd     = cd;
        r.sw     = sw;
        r.cow    = cow;
        request_queue.push_back(r);
    endtask

    // Walk directory and table for one command, update the tables, return the outcome
    function automatic outcome_t page_walk(request_t r);
        outcome_t    o;
        int unsigned di;
        int unsigned slot;
        int          k;
        low_bits_t   flags;
        entry_t      de;
        entry_t      te;
        o     = '{default: '0};
        di    = (r.va >> DIR_SHIFT) & (DIR_SLOTS - 1);
        slot  = di * TABLE_SLOTS + ((r.va >> PAGE_SHIFT) & (TABLE_SLOTS - 1));
        flags = r.kern ? E_GLOBAL : E_USER;
        if (r.wr)
            flags = flags | E_WRITE;
        if (r.wt)
            flags = flags | E_WTHRU;
        if (r.cd)
            flags = flags | E_NOCACHE;
        flags = flags | (r.sw ? E_SWAPPED : E_PRESENT);
        if (r.cow)
            flags = flags | E_COW;
        de = dir_model[di];
        te = table_model.exists(slot) ? table_model[slot] : '0;
        case (r.cmd) inside
            CMD_MAP:
            begin
                if (!de[B_PRESENT])
                begin
                    // new directory entry is present even for a swapped page
                    dir_model[di] = {r.tframe,
                        (flags & ~(E_GLOBAL | E_SWAPPED | E_COW)) | E_USER | E_WRITE | E_PRESENT};
                    for (k = 0; k < TABLE_SLOTS; k++)
                        table_model[di * TABLE_SLOTS + k] = '0;
                    te = '0;
                    tables_created++;
                end
                else if (flags[B_USER] && !de[B_USER])
                    dir_model[di] = de | ENTRY_WIDTH'(E_USER);
                if (!te[B_PRESENT])
                begin
                    table_model[slot] = {r.pframe, flags};
                    o.hit = 1'b1;
                end
            end
            CMD_QUERY:
            begin
                if (de[B_PRESENT])
                    o.hit = de[B_LARGE] || te[B_PRESENT];
            end
            CMD_UNMAP, CMD_GET, CMD_SET:
            begin
                if (!de[B_PRESENT] || de[B_LARGE] || !(te[B_PRESENT] || te[B_SWAPPED]))
                    o.misuse = 1'b1;
                else
                begin
                    o.hit = 1'b1;
                    if (r.cmd == CMD_UNMAP)
                        table_model[slot] = '0;
                    else if (r.cmd == CMD_SET)
                        table_model[slot] = {te[31:PAGE_SHIFT], flags};
                    else
                    begin
                        o.frame = te[31:PAGE_SHIFT];
                        o.kern  = !te[B_USER];
                        o.wr    = te[B_WRITE];
                        o.wt    = te[B_WTHRU];
                        o.cd    = te[B_NOCACHE];
                        o.sw    = te[B_SWAPPED];
                        o.cow   = te[B_COW];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Driver: present queued commands, hold while busy, idle in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            start      <= 1'b0;
            gap_left   = 0;
            quiet_left = 0;
        end
        else if (start && busy)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (request_queue.size() == 0)
            start <= 1'b0;
        else if (quiet_left == 0 && request_queue.size() > TAIL_ITEMS
                 && $urandom_range(0, 3) == 0)
        begin
            gap_left = $urandom_range(0, 12);
            start <= 1'b0;
        end
        else
        begin
            r = request_queue.pop_front();
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 15) == 0)
                quiet_left = $urandom_range(16, 48);
            command         <= r.cmd;
            virtual_address <= r.va;
            physical_frame  <= r.pframe;
            table_frame     <= r.tframe;
            kernel_mode     <= r.kern;
            writable        <= r.wr;
            write_through   <= r.wt;
            cache_disable   <= r.cd;
            swapped_out     <= r.sw;
            copy_on_write   <= r.cow;
            start           <= 1'b1;
        end
    end

    // Monitor: check the result first, then predict a command transferred at this edge
    always @(posedge clk)
    begin
        outcome_t want;
        request_t seen;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with no command outstanding", 1, 0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (success !== want.hit)
                        report_mismatch("success", success, want.hit);
                    if (misuse !== want.misuse)
                        report_mismatch("misuse", misuse, want.misuse);
                    if (out_frame !== want.frame)
                        report_mismatch("out_frame", out_frame, want.frame);
                    if (out_kernel_mode !== want.kern)
                        report_mismatch("out_kernel_mode", out_kernel_mode, want.kern);
                    if (out_writable !== want.wr)
                        report_mismatch("out_writable", out_writable, want.wr);
                    if (out_write_through !== want.wt)
                        report_mismatch("out_write_through", out_write_through, want.wt);
                    if (out_cache_disable !== want.cd)
                        report_mismatch("out_cache_disable", out_cache_disable, want.cd);
                    if (out_swapped !== want.sw)
                        report_mismatch("out_swapped", out_swapped, want.sw);
                    if (out_copy_on_write !== want.cow)
                        report_mismatch("out_copy_on_write", out_copy_on_write, want.cow);
                end
            end
            if (start && busy === 1'b0)
            begin
                seen.cmd    = command;
                seen.va     = virtual_address;
                seen.pframe = physical_frame;
                seen.tframe = table_frame;
                seen.kern   = kernel_mode;
                seen.wr     = writable;
                seen.wt     = write_through;
                seen.cd     = cache_disable;
                seen.sw     = swapped_out;
                seen.cow    = copy_on_write;
                want = page_walk(seen);
                pending_outcomes.push_back(want);
                cmd_count[seen.cmd]++;
                if (seen.cmd == CMD_MAP && want.hit)
                    pages_installed++;
                if (want.misuse)
                    misuse_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int          i;
        int          n;
        int          sel;
        command_t    cmd;
        logic [31:0] va;
        foreach (dir_model[d])
            dir_model[d] = '0;
        dir_pick[0] = 0;
        dir_pick[1] = DIR_SLOTS - 1;
        for (i = 2; i < 6; i++)
            dir_pick[i] = $urandom_range(1, DIR_SLOTS - 2);
        slot_pick[0] = 0;
        slot_pick[1] = TABLE_SLOTS - 1;
        for (i = 2; i < 12; i++)
            slot_pick[i] = $urandom_range(1, TABLE_SLOTS - 2);

        // directed: absent directory, fresh tables, swapped pages, top address, spare codes
        push_request(CMD_QUERY, 32'h0000_0000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_UNMAP, 32'h0000_0000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_GET,   32'h0000_0000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_SET,   32'h0000_0000, '0, '0, 1, 1, 1, 1, 1, 1);
        push_request(CMD_MAP,   32'h0000_0000, 20'h00000, 20'h00000, 1, 0, 0, 0, 0, 0);
        push_request(CMD_MAP,   32'h0000_0000, 20'hFFFFF, 20'hFFFFF, 0, 1, 1, 1, 0, 1);
        push_request(CMD_GET,   32'h0000_0FFF, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_MAP,   32'h0000_1FFF, 20'hFFFFF, 20'h12345, 0, 1, 1, 1, 1, 1);
        push_request(CMD_QUERY, 32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_GET,   32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_MAP,   32'h0000_1ABC, 20'hA5A5A, 20'h00000, 1, 0, 1, 0, 0, 0);
        push_request(CMD_SET,   32'h0000_1000, '0, '0, 1, 0, 0, 0, 0, 0);
        push_request(CMD_GET,   32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_UNMAP, 32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_UNMAP, 32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_GET,   32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_MAP,   32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 0, 1, 1, 1, 1, 1);
        push_request(CMD_GET,   32'hFFFF_F000, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_QUERY, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_SET,   32'hFFFF_FFFF, '0, '0, 1, 1, 0, 1, 0, 0);
        push_request(CMD_QUERY, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_SPARE5, 32'h0000_0000, 20'hFFFFF, 20'hFFFFF, 1, 1, 1, 1, 1, 1);
        push_request(CMD_SPARE6, 32'hFFFF_FFFF, '0, '0, 0, 0, 0, 0, 0, 0);
        push_request(CMD_SPARE7, 32'h0000_1000, '0, '0, 0, 0, 0, 0, 0, 0);

        // random: mostly a few hot directory slots and pages so that entries get reused
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 32)
                cmd = CMD_MAP;
            else if (sel < 44)
                cmd = CMD_UNMAP;
            else if (sel < 58)
                cmd = CMD_QUERY;
            else if (sel < 78)
                cmd = CMD_GET;
            else if (sel < 96)
                cmd = CMD_SET;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_SPARE5;
                    1:       cmd = CMD_SPARE6;
                    default: cmd = CMD_SPARE7;
                endcase
            end
            if ($urandom_range(0, 99) < 7)
                va = $urandom();
            else
                va = (dir_pick[$urandom_range(0, 5)] << DIR_SHIFT)
                   | (slot_pick[$urandom_range(0, 11)] << PAGE_SHIFT)
                   | $urandom_range(0, (1 << PAGE_SHIFT) - 1);
            push_request(cmd, va, frame_t'($urandom()), frame_t'($urandom()),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || start)
            @(posedge clk);
        for (n = 0; n < DRAIN_CYCLES && pending_outcomes.size() != 0; n++)
            @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results never returned", 0, pending_outcomes.size());
        repeat (8) @(posedge clk);

        $display("Covered map %0d, unmap %0d, query %0d, get %0d, set %0d, spare %0d commands",
                 cmd_count[CMD_MAP], cmd_count[CMD_UNMAP], cmd_count[CMD_QUERY],
                 cmd_count[CMD_GET], cmd_count[CMD_SET],
                 cmd_count[CMD_SPARE5] + cmd_count[CMD_SPARE6] + cmd_count[CMD_SPARE7]);
        $display("%0d tables created, %0d pages installed, %0d misuse results, %0d mismatches",
                 tables_created, pages_installed, misuse_seen, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
